>>> sv/time_entry_queue_with_swap_top_defines.svh
// assertion macros for the checker file
`ifndef TIME_ENTRY_QUEUE_WITH_SWAP_TOP_DEFINES_SVH
`define TIME_ENTRY_QUEUE_WITH_SWAP_TOP_DEFINES_SVH

// clocked assertion, masked while reset is high
`define TEQS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("teqs assertion failed");

// clocked assertion that also holds across reset
`define TEQS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("teqs assertion failed");

`endif

>>> sv/teqs_pkg.sv
package teqs_pkg;

  // entry layout: hour in upper bits, minute in lower bits
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int ENTRY_W  = HOUR_W + MINUTE_W;
  localparam int POS_W    = 8;

  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [HOUR_W-1:0]   MAX_HOUR   = 5'd23;
  localparam logic [MINUTE_W-1:0] MAX_MINUTE = 6'd59;

  // stream widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 3;

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_SWAP  = 3'd2,
    REQ_DUMP  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_NOPOS = 3'd3,
    ST_BAD   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWP_RB,
    S_SWP_WA,
    S_SWP_WB,
    S_DUMP
  } state_t;

endpackage

>>> sv/teqs_ram.sv
module teqs_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/time_entry_queue_with_swap_top.sv
// Time entry queue: a ring of QUEUE_DEPTH (hour, minute) entries in one RAM.
// Input stream s_*: one item per request; s_tuser is the request code
// (push, pop head, swap positions, dump all, clear), s_tdata the operands.
// Output stream m_*: m_tuser is the status, m_tdata carries missing_pos,
// hour_out and minute_out, m_tlast marks the final result of a request.
// Every request gives one result, except a dump of a non-empty queue,
// which gives one result per stored entry, head first.
// Flow: an item is taken in one cycle and decoded in the next. A swap
// uses the single RAM port pair for two reads and two writes, and a dump
// does one RAM read per entry.
// The block takes a new item while the previous result still sits in the
// output register; a stalled m_tready holds the pending result and stops
// the sequencer at its next result, never dropping one.
// Reset (synchronous, active high) empties the queue and the output
// register at once; the RAM is not cleared since only live entries are read.
module time_entry_queue_with_swap_top #(
  parameter int QUEUE_DEPTH = teqs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // hour_in[4:0], minute_in[10:5], pos_a[18:11], pos_b[26:19], zero[31:27]
  input  logic [teqs_pkg::S_TDATA_W-1:0] s_tdata,
  // req_type[2:0]
  input  logic [teqs_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // missing_pos[7:0], hour_out[12:8], minute_out[18:13], zero[23:19]
  output logic [teqs_pkg::M_TDATA_W-1:0] m_tdata,
  // status[2:0]
  output logic [teqs_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                           m_tlast
);

  import teqs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // ring slot of a position counted from a base slot
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t state, state_next;

  // queue control state
  logic [IDX_W-1:0] head_index;
  logic [CNT_W-1:0] entry_count;

  // latched request
  req_t                req_q;
  logic [HOUR_W-1:0]   hour_q;
  logic [MINUTE_W-1:0] minute_q;
  logic [POS_W-1:0]    pos_a_q, pos_b_q;

  logic [ENTRY_W-1:0] tmp_a;
  logic [IDX_W-1:0]   dump_idx;

  // output register
  status_t             out_status;
  logic [POS_W-1:0]    out_miss;
  logic [HOUR_W-1:0]   out_hour;
  logic [MINUTE_W-1:0] out_minute;
  logic                out_last;

  // ram port
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // decode results
  logic             accept, out_free;
  logic             q_empty, q_full;
  logic [POS_W-1:0] pos_lo, pos_hi;
  logic [IDX_W-1:0] slot_lo, slot_hi;
  status_t          dec_status;
  logic [POS_W-1:0] dec_miss;
  logic             do_push, do_pop, do_clear, swap_go, dump_go;
  logic             dump_last;

  // sequencer actions
  logic                emit;
  status_t             res_status;
  logic [POS_W-1:0]    res_miss;
  logic [HOUR_W-1:0]   res_hour;
  logic [MINUTE_W-1:0] res_minute;
  logic                res_last;
  logic                upd_push, upd_pop, upd_clear, dump_start, dump_step, cap_tmp;

  teqs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s_tready = (state == S_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign q_empty = (entry_count == '0);
  assign q_full  = (entry_count == CNT_W'(QUEUE_DEPTH));

  // swap positions ordered and mapped to ring slots
  assign pos_lo  = (pos_a_q < pos_b_q) ? pos_a_q : pos_b_q;
  assign pos_hi  = (pos_a_q < pos_b_q) ? pos_b_q : pos_a_q;
  assign slot_lo = slot_of(head_index, IDX_W'(pos_lo - 8'd1));
  assign slot_hi = slot_of(head_index, IDX_W'(pos_hi - 8'd1));

  assign dump_last = ((CNT_W'(dump_idx) + CNT_W'(1)) == entry_count);

  // request decode
  always_comb begin
    dec_status = ST_OK;
    dec_miss   = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    swap_go    = 1'b0;
    dump_go    = 1'b0;
    case (req_q)
      REQ_PUSH: begin
        if (hour_q > MAX_HOUR || minute_q > MAX_MINUTE) begin
          dec_status = ST_BAD;
        end else if (q_full) begin
          dec_status = ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      REQ_POP: begin
        if (q_empty) begin
          dec_status = ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      REQ_SWAP: begin
        if (pos_lo == '0) begin
          dec_status = ST_BAD;
        end else if (q_empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_lo > POS_W'(entry_count)) begin
          dec_status = ST_NOPOS;
          dec_miss   = pos_lo;
        end else if (pos_hi > POS_W'(entry_count)) begin
          dec_status = ST_NOPOS;
          dec_miss   = pos_hi;
        end else begin
          swap_go = 1'b1;
        end
      end
      REQ_DUMP: begin
        if (q_empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dump_go = 1'b1;
        end
      end
      REQ_CLEAR: begin
        do_clear   = 1'b1;
        dec_status = q_empty ? ST_EMPTY : ST_OK;
      end
      default: begin
        dec_status = ST_BAD;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dump_go) begin
          state_next = S_DUMP;
        end else if (swap_go) begin
          state_next = S_SWP_RB;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SWP_RB: state_next = S_SWP_WA;
      S_SWP_WA: state_next = S_SWP_WB;
      S_SWP_WB: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    emit       = 1'b0;
    res_status = ST_OK;
    res_miss   = '0;
    res_hour   = '0;
    res_minute = '0;
    res_last   = 1'b1;
    upd_push   = 1'b0;
    upd_pop    = 1'b0;
    upd_clear  = 1'b0;
    dump_start = 1'b0;
    dump_step  = 1'b0;
    cap_tmp    = 1'b0;
    case (state)
      S_EXEC: begin
        if (dump_go) begin
          ram_re     = 1'b1;
          ram_raddr  = head_index;
          dump_start = 1'b1;
        end else if (swap_go) begin
          ram_re    = 1'b1;
          ram_raddr = slot_lo;
        end else if (out_free) begin
          emit       = 1'b1;
          res_status = dec_status;
          res_miss   = dec_miss;
          upd_push   = do_push;
          upd_pop    = do_pop;
          upd_clear  = do_clear;
          ram_we     = do_push;
          ram_waddr  = slot_of(head_index, IDX_W'(entry_count));
          ram_wdata  = {hour_q, minute_q};
        end
      end
      S_SWP_RB: begin
        // first entry arrives, second read goes out
        ram_re    = 1'b1;
        ram_raddr = slot_hi;
        cap_tmp   = 1'b1;
      end
      S_SWP_WA: begin
        ram_we    = 1'b1;
        ram_waddr = slot_lo;
        ram_wdata = ram_rdata;
      end
      S_SWP_WB: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = slot_hi;
          ram_wdata = tmp_a;
          emit      = 1'b1;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit       = 1'b1;
          res_hour   = ram_rdata[ENTRY_W-1:MINUTE_W];
          res_minute = ram_rdata[MINUTE_W-1:0];
          res_last   = dump_last;
          if (!dump_last) begin
            ram_re    = 1'b1;
            ram_raddr = slot_of(head_index, dump_idx + IDX_W'(1));
            dump_step = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_index  <= '0;
      entry_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (upd_push) begin
        entry_count <= entry_count + CNT_W'(1);
      end else if (upd_pop) begin
        entry_count <= entry_count - CNT_W'(1);
        head_index  <= (entry_count == CNT_W'(1)) ? '0
                       : slot_of(head_index, IDX_W'(1));
      end else if (upd_clear) begin
        entry_count <= '0;
        head_index  <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= req_t'(s_tuser);
      hour_q   <= s_tdata[4:0];
      minute_q <= s_tdata[10:5];
      pos_a_q  <= s_tdata[18:11];
      pos_b_q  <= s_tdata[26:19];
    end
    if (cap_tmp) begin
      tmp_a <= ram_rdata;
    end
    if (dump_start) begin
      dump_idx <= '0;
    end else if (dump_step) begin
      dump_idx <= dump_idx + IDX_W'(1);
    end
    if (emit) begin
      out_status <= res_status;
      out_miss   <= res_miss;
      out_hour   <= res_hour;
      out_minute <= res_minute;
      out_last   <= res_last;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'd0, out_minute, out_hour, out_miss};
  assign m_tlast = out_last;

endmodule

>>> sv/teqs_checker.sv
`include "time_entry_queue_with_swap_top_defines.svh"

module teqs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [teqs_pkg::S_TDATA_W-1:0] s_tdata,
  input logic [teqs_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [teqs_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [teqs_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                           m_tlast
);

  import teqs_pkg::*;

  // a stalled result stays offered
  `TEQS_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)

  // only a dump gives more than one result, and all of them are ok
  `TEQS_ASSERT(a_multi_ok, clk, rst, m_tvalid && !m_tlast |-> m_tuser == ST_OK)

  // time fields stay zero unless an entry is shown
  `TEQS_ASSERT(a_time_zero, clk, rst, m_tvalid && m_tuser != ST_OK |-> m_tdata[18:8] == 11'd0)

  // missing position only with the no-position status
  `TEQS_ASSERT(a_miss_zero, clk, rst, m_tvalid && m_tuser != ST_NOPOS |-> m_tdata[7:0] == 8'd0)

  // reset empties the output register
  `TEQS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind time_entry_queue_with_swap_top teqs_checker u_teqs_checker (.*);

>>> tb/sv/time_entry_queue_with_swap_top_tb.sv
module time_entry_queue_with_swap_top_tb;
  import teqs_pkg::*;

  localparam int DEPTH  = DEF_QUEUE_DEPTH;
  localparam int RIDX_W = $clog2(DEPTH);

  // request codes the block does not define
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;

  localparam int NUM_PLAN = 24;

  // one request item, with an optional hand-written expected status
  typedef struct packed {
    logic [2:0]          req;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [POS_W-1:0]    pa;
    logic [POS_W-1:0]    pb;
    logic                typed;
    status_t             st;
    logic [POS_W-1:0]    miss;
  } step_t;

  // one result item
  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    miss;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                last;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  // predicted queue contents
  logic [ENTRY_W-1:0] ring [DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_count = 0;

  result_t     pending_results [$];
  int unsigned n_mismatch = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  // directed requests: empty queue cases, range limits, swap corners
  step_t plan [NUM_PLAN] = '{
    '{REQ_DUMP,  5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_EMPTY, 8'd0},
    '{REQ_POP,   5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_EMPTY, 8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd1,   8'd1,   1'b1, ST_EMPTY, 8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd0,   8'd3,   1'b1, ST_BAD,   8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd255, 8'd0,   1'b1, ST_BAD,   8'd0},
    '{REQ_CLEAR, 5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_EMPTY, 8'd0},
    '{REQ_PUSH,  5'd24, 6'd0,  8'd0,   8'd0,   1'b1, ST_BAD,   8'd0},
    '{REQ_PUSH,  5'd0,  6'd60, 8'd0,   8'd0,   1'b1, ST_BAD,   8'd0},
    '{REQ_PUSH,  5'd31, 6'd63, 8'd255, 8'd255, 1'b1, ST_BAD,   8'd0},
    '{REQ_PUSH,  5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_OK,    8'd0},
    '{REQ_PUSH,  5'd23, 6'd59, 8'd0,   8'd0,   1'b1, ST_OK,    8'd0},
    '{REQ_PUSH,  5'd12, 6'd30, 8'd0,   8'd0,   1'b0, ST_OK,    8'd0},
    '{REQ_RSVD_FIRST, 5'd0, 6'd0, 8'd0, 8'd0,  1'b1, ST_BAD,   8'd0},
    '{REQ_RSVD_LAST,  5'd0, 6'd0, 8'd0, 8'd0,  1'b1, ST_BAD,   8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd1,   8'd3,   1'b0, ST_OK,    8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd2,   8'd2,   1'b0, ST_OK,    8'd0},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd5,   8'd2,   1'b1, ST_NOPOS, 8'd5},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd255, 8'd4,   1'b1, ST_NOPOS, 8'd4},
    '{REQ_SWAP,  5'd0,  6'd0,  8'd3,   8'd255, 1'b1, ST_NOPOS, 8'd255},
    '{REQ_DUMP,  5'd0,  6'd0,  8'd0,   8'd0,   1'b0, ST_OK,    8'd0},
    '{REQ_POP,   5'd0,  6'd0,  8'd0,   8'd0,   1'b0, ST_OK,    8'd0},
    '{REQ_DUMP,  5'd0,  6'd0,  8'd0,   8'd0,   1'b0, ST_OK,    8'd0},
    '{REQ_CLEAR, 5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_OK,    8'd0},
    '{REQ_DUMP,  5'd0,  6'd0,  8'd0,   8'd0,   1'b1, ST_EMPTY, 8'd0}
  };

  time_entry_queue_with_swap_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic void post_result(status_t st, logic [POS_W-1:0] miss,
                                      logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn,
                                      logic lst);
    pending_results.push_back('{st, miss, hr, mn, lst});
  endfunction

  // queue behavior for one accepted request
  function automatic void apply_request(step_t s);
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [RIDX_W-1:0]  sl;
    logic [RIDX_W-1:0]  sh;
    logic [ENTRY_W-1:0] held;
    lo = (s.pa < s.pb) ? s.pa : s.pb;
    hi = (s.pa < s.pb) ? s.pb : s.pa;
    case (s.req)
      REQ_PUSH: begin
        if (s.hour > MAX_HOUR || s.minute > MAX_MINUTE) begin
          post_result(ST_BAD, '0, '0, '0, 1'b1);
        end else if (ring_count >= DEPTH) begin
          post_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          ring[RIDX_W'((ring_head + ring_count) % DEPTH)] = {s.hour, s.minute};
          ring_count++;
          post_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      REQ_POP: begin
        if (ring_count == 0) begin
          post_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
          if (ring_count == 0) ring_head = 0;
          post_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      REQ_SWAP: begin
        if (lo == 0) begin
          post_result(ST_BAD, '0, '0, '0, 1'b1);
        end else if (ring_count == 0) begin
          post_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else if (lo > ring_count) begin
          post_result(ST_NOPOS, lo, '0, '0, 1'b1);
        end else if (hi > ring_count) begin
          post_result(ST_NOPOS, hi, '0, '0, 1'b1);
        end else begin
          sl = RIDX_W'((ring_head + lo - 1) % DEPTH);
          sh = RIDX_W'((ring_head + hi - 1) % DEPTH);
          held = ring[sl];
          ring[sl] = ring[sh];
          ring[sh] = held;
          post_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (ring_count == 0) begin
          post_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            held = ring[RIDX_W'((ring_head + i) % DEPTH)];
            post_result(ST_OK, '0, held[ENTRY_W-1:MINUTE_W], held[MINUTE_W-1:0],
                        i + 1 == ring_count);
          end
        end
      end
      REQ_CLEAR: begin
        post_result((ring_count == 0) ? ST_EMPTY : ST_OK, '0, '0, '0, 1'b1);
        ring_count = 0;
        ring_head = 0;
      end
      default: begin
        post_result(ST_BAD, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // offer one request, optionally after an idle gap, and predict on acceptance
  task automatic send_item(step_t s);
    int unsigned queued_n;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= s.req;
    s_tdata <= {{(S_TDATA_W - 2*POS_W - ENTRY_W){1'b0}}, s.pb, s.pa, s.minute, s.hour};
    do @(posedge clk); while (!s_tready);
    queued_n = pending_results.size();
    apply_request(s);
    // hand-written expectation replaces the predicted one
    if (s.typed) begin
      while (pending_results.size() > queued_n) void'(pending_results.pop_back());
      post_result(s.st, s.miss, '0, '0, 1'b1);
    end
  endtask

  function automatic step_t random_step();
    step_t       s;
    int unsigned roll;
    s = '0;
    roll = $urandom_range(99);
    s.hour = HOUR_W'($urandom_range(MAX_HOUR));
    s.minute = MINUTE_W'($urandom_range(MAX_MINUTE));
    s.pa = POS_W'($urandom_range((1 << POS_W) - 1));
    s.pb = POS_W'($urandom_range((1 << POS_W) - 1));
    if (roll < 40) begin
      s.req = REQ_PUSH;
    end else if (roll < 50) begin
      // push with any field value, partly out of range
      s.req = REQ_PUSH;
      s.hour = HOUR_W'($urandom_range((1 << HOUR_W) - 1));
      s.minute = MINUTE_W'($urandom_range((1 << MINUTE_W) - 1));
    end else if (roll < 65) begin
      s.req = REQ_POP;
    end else if (roll < 80) begin
      s.req = REQ_SWAP;
      if (ring_count != 0 && $urandom_range(4) != 0) begin
        s.pa = POS_W'($urandom_range(ring_count, 1));
        s.pb = POS_W'($urandom_range(ring_count, 1));
      end
    end else if (roll < 90) begin
      s.req = REQ_DUMP;
    end else if (roll < 94) begin
      s.req = REQ_CLEAR;
    end else begin
      s.req = 3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
    end
    return s;
  endfunction

  // fill to capacity, overflow, dump all, then wrap the ring, swap across it and dump again
  task automatic fill_ring();
    step_t s;
    s = '0;
    s.req = REQ_PUSH;
    while (ring_count < DEPTH) begin
      s.hour = HOUR_W'($urandom_range(MAX_HOUR));
      s.minute = MINUTE_W'($urandom_range(MAX_MINUTE));
      send_item(s);
    end
    send_item(s);
    s.req = REQ_DUMP;
    send_item(s);
    s.req = REQ_POP;
    repeat (3) send_item(s);
    s.req = REQ_PUSH;
    repeat (3) begin
      s.hour = HOUR_W'($urandom_range(MAX_HOUR));
      s.minute = MINUTE_W'($urandom_range(MAX_MINUTE));
      send_item(s);
    end
    s.req = REQ_SWAP;
    s.pa = POS_W'(1);
    s.pb = POS_W'(DEPTH);
    send_item(s);
    s.req = REQ_DUMP;
    send_item(s);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n_rand,
                           bit with_fill);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    for (int k = 0; k < n_rand; k++) begin
      if (with_fill && k == n_rand / 2) fill_ring();
      send_item(random_step());
    end
    // sender holds off until every result is in
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{status_t'(m_tuser), m_tdata[7:0], m_tdata[12:8], m_tdata[18:13], m_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual status=%0d miss=%0d hour=%0d minute=%0d last=%0d",
                 $time, got.status, got.miss, got.hour, got.minute, got.last);
        n_mismatch++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          n_mismatch++;
        end
        if (got.miss !== want.miss) begin
          $display("%0t: missing_pos expected %0d actual %0d", $time, want.miss, got.miss);
          n_mismatch++;
        end
        if (got.hour !== want.hour) begin
          $display("%0t: hour_out expected %0d actual %0d", $time, want.hour, got.hour);
          n_mismatch++;
        end
        if (got.minute !== want.minute) begin
          $display("%0t: minute_out expected %0d actual %0d", $time, want.minute, got.minute);
          n_mismatch++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          n_mismatch++;
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_PLAN; i++) send_item(plan[i]);
    run_phase(0, 0, 16, 1'b0);
    run_phase(76, 0, 16, 1'b0);
    run_phase(0, 76, 16, 1'b1);
    run_phase(10, 10, 16, 1'b0);
    repeat (30) @(posedge clk);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/teqs_pkg.sv
sv/teqs_ram.sv
sv/time_entry_queue_with_swap_top.sv
sv/teqs_checker.sv
tb/sv/time_entry_queue_with_swap_top_tb.sv
